// ===== hdl/mer_pkg.sv =====
`timescale 1ns / 1ps

package mer_pkg;

    localparam int RAD_W   = 11;
    localparam int SQ_W    = 2 * RAD_W;
    localparam int OFFX_W  = 12;
    localparam int OFFY_W  = 13;
    localparam int TX_W    = OFFX_W + 1;
    localparam int TERM_W  = 36;
    localparam int DEC_W   = 50;
    localparam int OUT_W   = 14;
    localparam int COLOR_W = 32;
    localparam int MUL_A_W = 2 * TX_W;
    localparam int MUL_B_W = SQ_W;
    localparam int PROD_W  = MUL_A_W + MUL_B_W;

    localparam logic MODE_START = 1'b0;
    localparam logic MODE_STEP  = 1'b1;

    typedef enum logic [3:0] {
        S_IDLE,
        S_MUL_RX2,
        S_MUL_RY2,
        S_MUL_RXRY,
        S_INIT,
        S_SETTLE,
        S_REG_TX,
        S_REG_TY,
        S_REG_A,
        S_REG_B,
        S_REG_C,
        S_REG_D,
        S_ADV1,
        S_ADV2,
        S_OUT
    } t_state;

    typedef enum logic [3:0] {
        MUL_NONE,
        MUL_RX_RX,
        MUL_RY_RY,
        MUL_RX2_RY,
        MUL_TX_TX,
        MUL_TY_TY,
        MUL_RY2_TX2,
        MUL_RX2_TY2,
        MUL_RX2_RY2
    } t_mul_sel;

    typedef enum logic [3:0] {
        WB_NONE,
        WB_RX2,
        WB_RY2,
        WB_INIT,
        WB_TX2,
        WB_TY2,
        WB_DEC_SET,
        WB_DEC_ADD,
        WB_DEC_SUB
    } t_wb;

    typedef struct packed {
        logic     load;
        t_mul_sel mul_sel;
        t_wb      wb;
        logic     adv1;
        logic     adv2;
        logic     out_load;
        logic     out_null;
    } t_cmd;

    typedef struct packed {
        logic need_r2;
        logic more;
        logic out_free;
    } t_status;

endpackage

// ===== hdl/mer_ctrl.sv =====
`timescale 1ns / 1ps

module mer_ctrl (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_valid,
    input  logic             i_mode,
    output logic             o_stall,
    input  mer_pkg::t_status i_status,
    output mer_pkg::t_cmd    o_cmd
);

    mer_pkg::t_state r_state, n_state;
    logic            r_active, n_active;
    logic            r_start, n_start;
    logic            r_null, n_null;
    logic            w_accept;

    assign o_stall  = (r_state != mer_pkg::S_IDLE);
    assign w_accept = i_valid && (r_state == mer_pkg::S_IDLE);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= mer_pkg::S_IDLE;
            r_active <= 1'b0;
            r_start  <= 1'b0;
            r_null   <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_active <= n_active;
            r_start  <= n_start;
            r_null   <= n_null;
        end
    end

    // next state
    always_comb begin
        n_state  = r_state;
        n_active = r_active;
        n_start  = r_start;
        n_null   = r_null;
        unique case (r_state)
            mer_pkg::S_IDLE: begin
                if (w_accept) begin
                    n_null = 1'b0;
                    if (i_mode == mer_pkg::MODE_START) begin
                        n_state  = mer_pkg::S_MUL_RX2;
                        n_active = 1'b1;
                        n_start  = 1'b1;
                    end else if (r_active) begin
                        n_state = mer_pkg::S_ADV1;
                    end else begin
                        n_state = mer_pkg::S_OUT;
                        n_null  = 1'b1;
                    end
                end
            end
            mer_pkg::S_MUL_RX2:  n_state = mer_pkg::S_MUL_RY2;
            mer_pkg::S_MUL_RY2:  n_state = mer_pkg::S_MUL_RXRY;
            mer_pkg::S_MUL_RXRY: n_state = mer_pkg::S_INIT;
            mer_pkg::S_INIT:     n_state = mer_pkg::S_SETTLE;
            mer_pkg::S_SETTLE: begin
                priority if (i_status.need_r2) begin
                    n_state = mer_pkg::S_REG_TX;
                end else if (r_start) begin
                    // first set of a new ellipse is emitted after the first settle
                    n_state = mer_pkg::S_ADV1;
                    n_start = 1'b0;
                end else begin
                    n_state = mer_pkg::S_OUT;
                end
            end
            mer_pkg::S_REG_TX: n_state = mer_pkg::S_REG_TY;
            mer_pkg::S_REG_TY: n_state = mer_pkg::S_REG_A;
            mer_pkg::S_REG_A:  n_state = mer_pkg::S_REG_B;
            mer_pkg::S_REG_B:  n_state = mer_pkg::S_REG_C;
            mer_pkg::S_REG_C:  n_state = mer_pkg::S_REG_D;
            mer_pkg::S_REG_D:  n_state = mer_pkg::S_SETTLE;
            mer_pkg::S_ADV1:   n_state = mer_pkg::S_ADV2;
            mer_pkg::S_ADV2:   n_state = mer_pkg::S_SETTLE;
            mer_pkg::S_OUT: begin
                if (i_status.out_free) begin
                    n_state = mer_pkg::S_IDLE;
                    if (!r_null && !i_status.more) begin
                        n_active = 1'b0;
                    end
                end
            end
            default: n_state = mer_pkg::S_IDLE;
        endcase
    end

    // command outputs
    always_comb begin
        o_cmd          = '0;
        o_cmd.mul_sel  = mer_pkg::MUL_NONE;
        o_cmd.wb       = mer_pkg::WB_NONE;
        unique case (r_state)
            mer_pkg::S_IDLE: begin
                o_cmd.load = w_accept && (i_mode == mer_pkg::MODE_START);
            end
            mer_pkg::S_MUL_RX2: begin
                o_cmd.mul_sel = mer_pkg::MUL_RX_RX;
            end
            mer_pkg::S_MUL_RY2: begin
                o_cmd.mul_sel = mer_pkg::MUL_RY_RY;
                o_cmd.wb      = mer_pkg::WB_RX2;
            end
            mer_pkg::S_MUL_RXRY: begin
                o_cmd.mul_sel = mer_pkg::MUL_RX2_RY;
                o_cmd.wb      = mer_pkg::WB_RY2;
            end
            mer_pkg::S_INIT: begin
                o_cmd.wb = mer_pkg::WB_INIT;
            end
            mer_pkg::S_SETTLE: begin
            end
            mer_pkg::S_REG_TX: begin
                o_cmd.mul_sel = mer_pkg::MUL_TX_TX;
            end
            mer_pkg::S_REG_TY: begin
                o_cmd.mul_sel = mer_pkg::MUL_TY_TY;
                o_cmd.wb      = mer_pkg::WB_TX2;
            end
            mer_pkg::S_REG_A: begin
                o_cmd.mul_sel = mer_pkg::MUL_RY2_TX2;
                o_cmd.wb      = mer_pkg::WB_TY2;
            end
            mer_pkg::S_REG_B: begin
                o_cmd.mul_sel = mer_pkg::MUL_RX2_TY2;
                o_cmd.wb      = mer_pkg::WB_DEC_SET;
            end
            mer_pkg::S_REG_C: begin
                o_cmd.mul_sel = mer_pkg::MUL_RX2_RY2;
                o_cmd.wb      = mer_pkg::WB_DEC_ADD;
            end
            mer_pkg::S_REG_D: begin
                o_cmd.wb = mer_pkg::WB_DEC_SUB;
            end
            mer_pkg::S_ADV1: begin
                o_cmd.adv1 = 1'b1;
            end
            mer_pkg::S_ADV2: begin
                o_cmd.adv2 = 1'b1;
            end
            mer_pkg::S_OUT: begin
                o_cmd.out_load = i_status.out_free;
                o_cmd.out_null = r_null;
            end
            default: begin
            end
        endcase
    end

    a_accept_leaves_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept |=> (r_state != mer_pkg::S_IDLE))
        else $error("accepted beat did not start work");

    a_start_sets_active: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.load |=> r_active)
        else $error("start beat did not mark the ellipse active");

    a_null_only_inactive: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((r_state == mer_pkg::S_OUT) && r_null) |-> !r_active)
        else $error("empty result while an ellipse is active");

endmodule

// ===== hdl/mer_dp.sv =====
`timescale 1ns / 1ps

module mer_dp #(
    parameter int COORD_BITS = 12
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  mer_pkg::t_cmd                     i_cmd,
    output mer_pkg::t_status                  o_status,
    input  logic [mer_pkg::RAD_W-1:0]         i_radius_x,
    input  logic [mer_pkg::RAD_W-1:0]         i_radius_y,
    input  logic [COORD_BITS-1:0]             i_center_x,
    input  logic [COORD_BITS-1:0]             i_center_y,
    input  logic [mer_pkg::COLOR_W-1:0]       i_draw_color,
    input  logic                              i_stall,
    output logic                              o_valid,
    output logic                              o_point_valid,
    output logic                              o_last_set,
    output logic signed [mer_pkg::OUT_W-1:0]  o_right_x,
    output logic signed [mer_pkg::OUT_W-1:0]  o_left_x,
    output logic signed [mer_pkg::OUT_W-1:0]  o_lower_y,
    output logic signed [mer_pkg::OUT_W-1:0]  o_upper_y,
    output logic [mer_pkg::COLOR_W-1:0]       o_pixel_color
);

    localparam int RAD_W   = mer_pkg::RAD_W;
    localparam int SQ_W    = mer_pkg::SQ_W;
    localparam int OFFX_W  = mer_pkg::OFFX_W;
    localparam int OFFY_W  = mer_pkg::OFFY_W;
    localparam int TX_W    = mer_pkg::TX_W;
    localparam int TERM_W  = mer_pkg::TERM_W;
    localparam int DEC_W   = mer_pkg::DEC_W;
    localparam int OUT_W   = mer_pkg::OUT_W;
    localparam int COLOR_W = mer_pkg::COLOR_W;
    localparam int MUL_A_W = mer_pkg::MUL_A_W;
    localparam int MUL_B_W = mer_pkg::MUL_B_W;
    localparam int PROD_W  = mer_pkg::PROD_W;
    localparam int SUM_W   = ((COORD_BITS > OFFY_W) ? COORD_BITS : OFFY_W) + 2;

    // latched ellipse
    logic [RAD_W-1:0]         r_rx, r_ry;
    logic [COORD_BITS-1:0]    r_cx, r_cy;
    logic [COLOR_W-1:0]       r_color;
    logic [SQ_W-1:0]          r_rx2, r_ry2;

    // iteration state
    logic                     r_r2;
    logic                     r_br;
    logic [OFFX_W-1:0]        r_offx;
    logic signed [OFFY_W-1:0] r_offy;
    logic signed [TERM_W-1:0] r_stepx, r_stepy;
    logic signed [DEC_W-1:0]  r_dec;

    // multiplier
    logic [MUL_A_W-1:0]       w_ma, r_tx2, r_ty2;
    logic [MUL_B_W-1:0]       w_mb;
    logic [PROD_W-1:0]        r_prod;
    logic [TX_W-1:0]          w_tx, w_ty_mag;
    logic signed [OFFY_W-1:0] w_ty;

    // pending set and output register
    logic [OUT_W-1:0]         r_pend_rx, r_pend_lx, r_pend_ly, r_pend_uy;
    logic                     r_out_valid;

    logic signed [SUM_W-1:0]  w_cx, w_cy, w_ox, w_oy, w_rx_s, w_lx_s, w_ly_s, w_uy_s;
    logic signed [TERM_W-1:0] w_2rx2, w_2ry2;
    logic signed [DEC_W-1:0]  w_rx2_d, w_ry2_d, w_prod_d, w_sx_d, w_sy_d, w_rt_d, w_dterm;
    logic                     w_region_one;

    assign w_tx     = {r_offx, 1'b1};
    assign w_ty     = r_offy - OFFY_W'(1);
    assign w_ty_mag = w_ty[OFFY_W-1] ? TX_W'(-w_ty) : TX_W'(w_ty);

    always_comb begin
        unique case (i_cmd.mul_sel)
            mer_pkg::MUL_RX_RX: begin
                w_ma = MUL_A_W'(r_rx);
                w_mb = MUL_B_W'(r_rx);
            end
            mer_pkg::MUL_RY_RY: begin
                w_ma = MUL_A_W'(r_ry);
                w_mb = MUL_B_W'(r_ry);
            end
            mer_pkg::MUL_RX2_RY: begin
                w_ma = MUL_A_W'(r_rx2);
                w_mb = MUL_B_W'(r_ry);
            end
            mer_pkg::MUL_TX_TX: begin
                w_ma = MUL_A_W'(w_tx);
                w_mb = MUL_B_W'(w_tx);
            end
            mer_pkg::MUL_TY_TY: begin
                w_ma = MUL_A_W'(w_ty_mag);
                w_mb = MUL_B_W'(w_ty_mag);
            end
            mer_pkg::MUL_RY2_TX2: begin
                w_ma = r_tx2;
                w_mb = r_ry2;
            end
            mer_pkg::MUL_RX2_TY2: begin
                w_ma = r_ty2;
                w_mb = r_rx2;
            end
            mer_pkg::MUL_RX2_RY2: begin
                w_ma = MUL_A_W'(r_rx2);
                w_mb = r_ry2;
            end
            default: begin
                w_ma = '0;
                w_mb = '0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_prod <= PROD_W'(w_ma) * PROD_W'(w_mb);
    end

    assign w_2rx2   = TERM_W'({r_rx2, 1'b0});
    assign w_2ry2   = TERM_W'({r_ry2, 1'b0});
    assign w_rx2_d  = DEC_W'(r_rx2);
    assign w_ry2_d  = DEC_W'(r_ry2);
    assign w_prod_d = DEC_W'(r_prod);

    // decision update: both regions share stepx - stepy + r^2 with terms dropped per branch
    assign w_region_one = !r_r2;
    assign w_sx_d  = (w_region_one || r_br) ? DEC_W'(r_stepx) : '0;
    assign w_sy_d  = (r_r2 || r_br) ? DEC_W'(r_stepy) : '0;
    assign w_rt_d  = r_r2 ? w_rx2_d : w_ry2_d;
    assign w_dterm = w_sx_d - w_sy_d + w_rt_d;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_r2 <= 1'b0;
        end else if (i_cmd.wb == mer_pkg::WB_INIT) begin
            r_r2 <= 1'b0;
        end else if (i_cmd.wb == mer_pkg::WB_DEC_SUB) begin
            r_r2 <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_rx    <= i_radius_x;
            r_ry    <= i_radius_y;
            r_cx    <= i_center_x;
            r_cy    <= i_center_y;
            r_color <= i_draw_color;
        end
        unique case (i_cmd.wb)
            mer_pkg::WB_RX2: r_rx2 <= r_prod[SQ_W-1:0];
            mer_pkg::WB_RY2: r_ry2 <= r_prod[SQ_W-1:0];
            mer_pkg::WB_INIT: begin
                r_offx  <= '0;
                r_offy  <= OFFY_W'(r_ry);
                r_stepx <= '0;
                r_stepy <= TERM_W'({r_prod, 1'b0});
                r_dec   <= (w_ry2_d <<< 2) - (w_prod_d <<< 2) + w_rx2_d;
            end
            mer_pkg::WB_TX2:     r_tx2 <= r_prod[MUL_A_W-1:0];
            mer_pkg::WB_TY2:     r_ty2 <= r_prod[MUL_A_W-1:0];
            mer_pkg::WB_DEC_SET: r_dec <= w_prod_d;
            mer_pkg::WB_DEC_ADD: r_dec <= r_dec + (w_prod_d <<< 2);
            mer_pkg::WB_DEC_SUB: r_dec <= r_dec - (w_prod_d <<< 2);
            default: begin
            end
        endcase
        if (i_cmd.adv1) begin
            r_pend_rx <= w_rx_s[OUT_W-1:0];
            r_pend_lx <= w_lx_s[OUT_W-1:0];
            r_pend_ly <= w_ly_s[OUT_W-1:0];
            r_pend_uy <= w_uy_s[OUT_W-1:0];
            if (w_region_one) begin
                r_offx  <= r_offx + OFFX_W'(1);
                r_stepx <= r_stepx + w_2ry2;
                r_br    <= !r_dec[DEC_W-1];
                if (!r_dec[DEC_W-1]) begin
                    r_offy  <= r_offy - OFFY_W'(1);
                    r_stepy <= r_stepy - w_2rx2;
                end
            end else begin
                r_offy  <= r_offy - OFFY_W'(1);
                r_stepy <= r_stepy - w_2rx2;
                r_br    <= !(r_dec > 0);
                if (!(r_dec > 0)) begin
                    r_offx  <= r_offx + OFFX_W'(1);
                    r_stepx <= r_stepx + w_2ry2;
                end
            end
        end
        if (i_cmd.adv2) begin
            r_dec <= r_dec + (w_dterm <<< 2);
        end
    end

    // coordinates of the current set
    assign w_cx   = SUM_W'(r_cx);
    assign w_cy   = SUM_W'(r_cy);
    assign w_ox   = SUM_W'(r_offx);
    assign w_oy   = SUM_W'(r_offy);
    assign w_rx_s = w_cx + w_ox;
    assign w_lx_s = w_cx - w_ox;
    assign w_ly_s = w_cy + w_oy;
    assign w_uy_s = w_cy - w_oy;

    assign o_status.need_r2  = !r_r2 && !(r_stepx < r_stepy);
    assign o_status.more     = r_r2 ? !r_offy[OFFY_W-1] : 1'b1;
    assign o_status.out_free = !r_out_valid || !i_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.out_load) begin
            r_out_valid <= 1'b1;
        end else if (!i_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            if (i_cmd.out_null) begin
                o_point_valid <= 1'b0;
                o_last_set    <= 1'b0;
                o_right_x     <= '0;
                o_left_x      <= '0;
                o_lower_y     <= '0;
                o_upper_y     <= '0;
                o_pixel_color <= '0;
            end else begin
                o_point_valid <= 1'b1;
                o_last_set    <= !o_status.more;
                o_right_x     <= r_pend_rx;
                o_left_x      <= r_pend_lx;
                o_lower_y     <= r_pend_ly;
                o_upper_y     <= r_pend_uy;
                o_pixel_color <= r_color;
            end
        end
    end

    assign o_valid = r_out_valid;

    a_load_shows_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.out_load |=> r_out_valid)
        else $error("result load did not raise valid");

    a_region_two_sticky: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ($fell(r_r2) && $past(i_rst_n)) |-> ($past(i_cmd.wb) == mer_pkg::WB_INIT))
        else $error("left region two without a new ellipse");

    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && i_stall) |-> !i_cmd.out_load)
        else $error("result overwritten while stalled");

endmodule

// ===== hdl/midpoint_ellipse_rasterizer.sv =====
`timescale 1ns / 1ps
// channel  | handshake          | payload
// input    | i_valid / o_stall  | i_mode, i_radius_x, i_radius_y, i_center_x, i_center_y,
//          |                    | i_draw_color
// output   | o_valid / i_stall  | o_point_valid, o_last_set, o_right_x, o_left_x,
//          |                    | o_lower_y, o_upper_y, o_pixel_color
//
// one beat in flight; a step loads the result register after the two advance states and the
// region check, once the output register is free, and the next beat is taken after that load.
// a start first forms the radius products on the shared multiplier, sets up the decision
// and does the first region check; the region change adds chained products plus a recheck.
// synchronous active-low reset clears control state; no clearing pass.
// a stalled result holds in the output register; a new beat is taken meanwhile and waits
// for it before its own result is loaded.

module midpoint_ellipse_rasterizer #(
    parameter int COORD_BITS = 12
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_valid,
    output logic                              o_stall,
    input  logic                              i_mode,
    input  logic [mer_pkg::RAD_W-1:0]         i_radius_x,
    input  logic [mer_pkg::RAD_W-1:0]         i_radius_y,
    input  logic [COORD_BITS-1:0]             i_center_x,
    input  logic [COORD_BITS-1:0]             i_center_y,
    input  logic [mer_pkg::COLOR_W-1:0]       i_draw_color,
    output logic                              o_valid,
    input  logic                              i_stall,
    output logic                              o_point_valid,
    output logic                              o_last_set,
    output logic signed [mer_pkg::OUT_W-1:0]  o_right_x,
    output logic signed [mer_pkg::OUT_W-1:0]  o_left_x,
    output logic signed [mer_pkg::OUT_W-1:0]  o_lower_y,
    output logic signed [mer_pkg::OUT_W-1:0]  o_upper_y,
    output logic [mer_pkg::COLOR_W-1:0]       o_pixel_color
);

    mer_pkg::t_cmd    w_cmd;
    mer_pkg::t_status w_status;

    mer_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (i_valid),
        .i_mode   (i_mode),
        .o_stall  (o_stall),
        .i_status (w_status),
        .o_cmd    (w_cmd)
    );

    mer_dp #(
        .COORD_BITS (COORD_BITS)
    ) u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (w_cmd),
        .o_status      (w_status),
        .i_radius_x    (i_radius_x),
        .i_radius_y    (i_radius_y),
        .i_center_x    (i_center_x),
        .i_center_y    (i_center_y),
        .i_draw_color  (i_draw_color),
        .i_stall       (i_stall),
        .o_valid       (o_valid),
        .o_point_valid (o_point_valid),
        .o_last_set    (o_last_set),
        .o_right_x     (o_right_x),
        .o_left_x      (o_left_x),
        .o_lower_y     (o_lower_y),
        .o_upper_y     (o_upper_y),
        .o_pixel_color (o_pixel_color)
    );

endmodule

// ===== verif/tb.sv =====
`timescale 1ns / 1ps

module tb;

    localparam int  RANDOM_BEATS = 1600;
    localparam int  DRAIN_LIMIT  = 20000;
    localparam int  TAIL_CYCLES  = 40;
    localparam real RUN_LIMIT_NS = 3_200_000.0;

    typedef struct {
        logic                          mode;
        logic [mer_pkg::RAD_W-1:0]     radius_x;
        logic [mer_pkg::RAD_W-1:0]     radius_y;
        logic [11:0]                   center_x;
        logic [11:0]                   center_y;
        logic [mer_pkg::COLOR_W-1:0]   draw_color;
    } t_ellipse_cmd;

    typedef struct {
        logic                          point_valid;
        logic                          last_set;
        logic [mer_pkg::OUT_W-1:0]     right_x;
        logic [mer_pkg::OUT_W-1:0]     left_x;
        logic [mer_pkg::OUT_W-1:0]     lower_y;
        logic [mer_pkg::OUT_W-1:0]     upper_y;
        logic [mer_pkg::COLOR_W-1:0]   color;
    } t_point_set;

    typedef enum {STALL_NONE, STALL_LIGHT, STALL_HEAVY, STALL_PERIODIC} t_stall_mode;

    logic                                i_clk;
    logic                                i_rst_n;
    logic                                i_valid;
    logic                                o_stall;
    logic                                i_mode;
    logic [mer_pkg::RAD_W-1:0]           i_radius_x;
    logic [mer_pkg::RAD_W-1:0]           i_radius_y;
    logic [11:0]                         i_center_x;
    logic [11:0]                         i_center_y;
    logic [mer_pkg::COLOR_W-1:0]         i_draw_color;
    logic                                o_valid;
    logic                                i_stall;
    logic                                o_point_valid;
    logic                                o_last_set;
    logic signed [mer_pkg::OUT_W-1:0]    o_right_x;
    logic signed [mer_pkg::OUT_W-1:0]    o_left_x;
    logic signed [mer_pkg::OUT_W-1:0]    o_lower_y;
    logic signed [mer_pkg::OUT_W-1:0]    o_upper_y;
    logic [mer_pkg::COLOR_W-1:0]         o_pixel_color;

    // predicted rasterizer state
    bit      ell_active;
    bit      ell_region_two;
    longint  ell_ox;
    longint  ell_oy;
    longint  ell_sx;
    longint  ell_sy;
    longint  ell_dec;
    longint  lat_rx;
    longint  lat_ry;
    longint  lat_cx;
    longint  lat_cy;
    logic [mer_pkg::COLOR_W-1:0] lat_color;

    t_point_set  pending_sets[$];
    int          mismatch_count;
    int          beats_sent;
    int          burst_left;
    int          rx_hold_left;
    int          rx_phase;
    t_stall_mode stall_mode;

    midpoint_ellipse_rasterizer i_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (i_valid),
        .o_stall       (o_stall),
        .i_mode        (i_mode),
        .i_radius_x    (i_radius_x),
        .i_radius_y    (i_radius_y),
        .i_center_x    (i_center_x),
        .i_center_y    (i_center_y),
        .i_draw_color  (i_draw_color),
        .o_valid       (o_valid),
        .i_stall       (i_stall),
        .o_point_valid (o_point_valid),
        .o_last_set    (o_last_set),
        .o_right_x     (o_right_x),
        .o_left_x      (o_left_x),
        .o_lower_y     (o_lower_y),
        .o_upper_y     (o_upper_y),
        .o_pixel_color (o_pixel_color)
    );

    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    initial begin
        #(RUN_LIMIT_NS);
        $display("midpoint_ellipse_rasterizer verification failed");
        $finish;
    end

    // switch to region two once the x term catches the y term
    function automatic bit region_check();
        longint rx2;
        longint ry2;
        longint tx;
        longint ty;
        rx2 = lat_rx * lat_rx;
        ry2 = lat_ry * lat_ry;
        if (!ell_region_two && !(ell_sx < ell_sy)) begin
            tx = 2 * ell_ox + 1;
            ty = ell_oy - 1;
            ell_region_two = 1'b1;
            ell_dec = ry2 * tx * tx + 4 * rx2 * ty * ty - 4 * rx2 * ry2;
        end
        if (ell_region_two)
            return ell_oy >= 0;
        return 1'b1;
    endfunction

    function automatic void trace_ellipse(t_ellipse_cmd c);
        t_point_set s;
        longint     rx2;
        longint     ry2;
        bit         more;
        s = '{default: '0};
        if (c.mode == mer_pkg::MODE_START) begin
            lat_rx         = longint'(c.radius_x);
            lat_ry         = longint'(c.radius_y);
            lat_cx         = longint'(c.center_x);
            lat_cy         = longint'(c.center_y);
            lat_color      = c.draw_color;
            ell_active     = 1'b1;
            ell_region_two = 1'b0;
            ell_ox         = 0;
            ell_oy         = lat_ry;
            ell_sx         = 0;
            ell_sy         = 2 * lat_rx * lat_rx * lat_ry;
            ell_dec        = 4 * lat_ry * lat_ry - 4 * lat_rx * lat_rx * lat_ry + lat_rx * lat_rx;
            void'(region_check());
        end else if (!ell_active) begin
            pending_sets.push_back(s);
            return;
        end
        s.point_valid = 1'b1;
        s.right_x     = 14'(lat_cx + ell_ox);
        s.left_x      = 14'(lat_cx - ell_ox);
        s.lower_y     = 14'(lat_cy + ell_oy);
        s.upper_y     = 14'(lat_cy - ell_oy);
        s.color       = lat_color;

        rx2 = lat_rx * lat_rx;
        ry2 = lat_ry * lat_ry;
        if (!ell_region_two) begin
            ell_ox++;
            ell_sx += 2 * ry2;
            if (ell_dec < 0) begin
                ell_dec += 4 * (ell_sx + ry2);
            end else begin
                ell_oy--;
                ell_sy -= 2 * rx2;
                ell_dec += 4 * (ell_sx - ell_sy + ry2);
            end
        end else begin
            ell_oy--;
            ell_sy -= 2 * rx2;
            if (ell_dec > 0) begin
                ell_dec += 4 * (rx2 - ell_sy);
            end else begin
                ell_ox++;
                ell_sx += 2 * ry2;
                ell_dec += 4 * (ell_sx - ell_sy + rx2);
            end
        end
        more = region_check();
        if (!more)
            ell_active = 1'b0;
        s.last_set = !more;
        pending_sets.push_back(s);
    endfunction

    function automatic void check_field(string name, logic [31:0] exp_v, logic [31:0] act_v);
        if (exp_v !== act_v) begin
            mismatch_count++;
            $display("%0t: %s mismatch, expected %h, actual %h", $time, name, exp_v, act_v);
        end
    endfunction

    // result checker
    always @(posedge i_clk) begin
        t_point_set e;
        if (i_rst_n && o_valid && !i_stall) begin
            if (pending_sets.size() == 0) begin
                mismatch_count++;
                $display("%0t: unexpected beat, expected none, actual valid=%b last=%b",
                         $time, o_point_valid, o_last_set);
            end else begin
                e = pending_sets.pop_front();
                check_field("point_valid", 32'(e.point_valid), 32'(o_point_valid));
                check_field("last_set", 32'(e.last_set), 32'(o_last_set));
                check_field("right_x", 32'(e.right_x), 32'($unsigned(o_right_x)));
                check_field("left_x", 32'(e.left_x), 32'($unsigned(o_left_x)));
                check_field("lower_y", 32'(e.lower_y), 32'($unsigned(o_lower_y)));
                check_field("upper_y", 32'(e.upper_y), 32'($unsigned(o_upper_y)));
                check_field("pixel_color", e.color, o_pixel_color);
            end
        end
    end

    // receiver backpressure, with a stall pattern that is redrawn at random
    initial begin
        i_stall    = 1'b0;
        stall_mode = STALL_NONE;
        forever begin
            @(negedge i_clk);
            rx_phase++;
            if (rx_phase % 96 == 0)
                stall_mode = t_stall_mode'($urandom_range(0, 3));
            if (rx_hold_left > 0) begin
                rx_hold_left--;
                i_stall <= 1'b1;
            end else begin
                case (stall_mode)
                    STALL_NONE:  i_stall <= 1'b0;
                    STALL_LIGHT: i_stall <= ($urandom_range(0, 3) == 0);
                    STALL_HEAVY: i_stall <= ($urandom_range(0, 3) != 0);
                    default:     i_stall <= (rx_phase % 5 < 2);
                endcase
            end
        end
    end

    function automatic t_ellipse_cmd start_cmd(int rx, int ry, int cx, int cy,
                                               logic [31:0] color);
        t_ellipse_cmd c;
        c.mode       = mer_pkg::MODE_START;
        c.radius_x   = 11'(rx);
        c.radius_y   = 11'(ry);
        c.center_x   = 12'(cx);
        c.center_y   = 12'(cy);
        c.draw_color = color;
        return c;
    endfunction

    // step beats carry junk in the fields the block ignores
    function automatic t_ellipse_cmd step_cmd();
        t_ellipse_cmd c;
        c            = start_cmd($urandom, $urandom, $urandom, $urandom, $urandom);
        c.mode       = mer_pkg::MODE_STEP;
        return c;
    endfunction

    task automatic send_beat(t_ellipse_cmd c);
        @(negedge i_clk);
        i_valid      <= 1'b1;
        i_mode       <= c.mode;
        i_radius_x   <= c.radius_x;
        i_radius_y   <= c.radius_y;
        i_center_x   <= c.center_x;
        i_center_y   <= c.center_y;
        i_draw_color <= c.draw_color;
        do @(posedge i_clk); while (o_stall);
        trace_ellipse(c);
        beats_sent++;
    endtask

    task automatic run_until_done(int cap);
        int n;
        n = 0;
        while (ell_active && n < cap) begin
            send_beat(step_cmd());
            n++;
        end
    endtask

    task automatic drain_sets();
        int n;
        n = 0;
        @(negedge i_clk);
        i_valid <= 1'b0;
        while (pending_sets.size() != 0 && n < DRAIN_LIMIT) begin
            @(posedge i_clk);
            n++;
        end
    endtask

    // bursts of random length; some bursts start with no gap at all
    task automatic pace_sender();
        int gap;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 40);
            gap        = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
            repeat (gap) begin
                @(negedge i_clk);
                i_valid <= 1'b0;
            end
        end
        burst_left--;
    endtask

    task automatic test_no_ellipse();
        send_beat(step_cmd());
    endtask

    task automatic test_degenerate_axes();
        // zero radii: one set at the center, then nothing active
        send_beat(start_cmd(0, 0, 0, 0, 32'h0));
        send_beat(step_cmd());
        // zero horizontal radius walks the vertical axis
        send_beat(start_cmd(0, 3, 4095, 4095, 32'hFFFF_FFFF));
        run_until_done(10);
        send_beat(start_cmd(3, 0, 2048, 17, 32'hA5A5_5A5A));
    endtask

    task automatic test_extreme_radii();
        send_beat(start_cmd(2047, 2047, 4095, 0, 32'h8000_0001));
        repeat (2) send_beat(step_cmd());
        // restart while the previous ellipse is still running
        send_beat(start_cmd(2047, 1, 0, 4095, 32'h7FFF_FFFE));
        repeat (2) send_beat(step_cmd());
        // region change on the first step with a large vertical offset
        send_beat(start_cmd(1, 2047, 1365, 2730, 32'h0123_4567));
        repeat (3) send_beat(step_cmd());
        send_beat(start_cmd(2, 3, 100, 200, 32'hDEAD_BEEF));
        run_until_done(20);
        send_beat(step_cmd());
    endtask

    task automatic test_backpressure();
        rx_hold_left = 60;
        send_beat(start_cmd(20, 20, 1000, 1000, $urandom));
        repeat (15) send_beat(step_cmd());
        drain_sets();
        run_until_done(200);
        drain_sets();
    endtask

    task automatic test_random_ellipses();
        int base;
        int rx;
        int ry;
        int cap;
        int kind;
        base = beats_sent;
        while (beats_sent - base < RANDOM_BEATS) begin
            if ($urandom_range(0, 9) == 0) begin
                // stray steps, invalid unless an ellipse was left running
                repeat ($urandom_range(1, 3)) begin
                    pace_sender();
                    send_beat(step_cmd());
                end
            end else begin
                kind = $urandom_range(0, 19);
                cap  = 400;
                if (kind < 14) begin
                    rx = $urandom_range(0, 12);
                    ry = $urandom_range(0, 12);
                end else if (kind < 17) begin
                    rx = $urandom_range(0, 80);
                    ry = $urandom_range(0, 80);
                end else begin
                    rx  = (kind == 18) ? $urandom_range(0, 12) : $urandom_range(0, 2047);
                    ry  = (kind == 17) ? $urandom_range(0, 12) : $urandom_range(0, 2047);
                    cap = 250;
                end
                if ($urandom_range(0, 7) == 0)
                    cap = $urandom_range(0, 3);
                pace_sender();
                send_beat(start_cmd(rx, ry, $urandom_range(0, 4095),
                                    $urandom_range(0, 4095), $urandom));
                for (int n = 0; n < cap && ell_active; n++) begin
                    pace_sender();
                    send_beat(step_cmd());
                end
            end
        end
        drain_sets();
    endtask

    initial begin
        i_rst_n      = 1'b0;
        i_valid      = 1'b0;
        i_mode       = mer_pkg::MODE_START;
        i_radius_x   = '0;
        i_radius_y   = '0;
        i_center_x   = '0;
        i_center_y   = '0;
        i_draw_color = '0;
        repeat (12) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        test_no_ellipse();
        test_degenerate_axes();
        test_extreme_radii();
        drain_sets();
        test_backpressure();
        test_random_ellipses();

        drain_sets();
        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (pending_sets.size() != 0) begin
            mismatch_count++;
            $display("%0t: results missing, expected %0d more, actual 0",
                     $time, pending_sets.size());
        end
        if (mismatch_count == 0)
            $display("midpoint_ellipse_rasterizer verification clean");
        else
            $display("midpoint_ellipse_rasterizer verification failed");
        $finish;
    end

endmodule

// ===== filelist.f =====
hdl/mer_pkg.sv
hdl/mer_ctrl.sv
hdl/mer_dp.sv
hdl/midpoint_ellipse_rasterizer.sv
verif/tb.sv
